@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL files.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed: next-cycle implication");

`endif

@@ rtl/mcc_pkg.sv @@
// Types and constants of the min coin change table.
// No dependencies; used by mcc_ctrl, mcc_dp and min_coin_change_table.
package mcc_pkg;

	localparam int AMT_W         = 10;
	localparam int CNT_W         = 10;
	localparam int SLOT_W        = 3;
	localparam int COIN_W        = 10;
	localparam int NUM_COIN_REGS = 7;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 10;
	localparam int S_TDATA_W     = 16;
	localparam int M_TDATA_W     = 24;
	localparam int AMT_MAX       = 1023;

	localparam int DEF_MAX_AMOUNT = 1023;
	localparam int DEF_COIN_SLOTS = 7;

	localparam logic [CNT_W-1:0] COUNT_SAT = 10'd1023;

	localparam logic [CFG_IDX_W-1:0] REG_COIN_COUNT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COIN_VALUE_0 = 3'd1;

	localparam logic MODE_COMPUTE = 1'b0;
	localparam logic MODE_QUERY   = 1'b1;

	typedef struct packed {
		logic              reach;
		logic [CNT_W-1:0]  count;
		logic [SLOT_W-1:0] slot;
	} mcc_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ZERO,
		ST_FILL,
		ST_RD,
		ST_OUT
	} mcc_state_t;

	typedef struct packed {
		logic accept;   // latch the input beat
		logic zero_wr;  // write entry zero, start the fill
		logic fill;     // one phase of the amount/slot walk
		logic rd;       // read the result entry
		logic load;     // load the output register
	} mcc_cmd_t;

	typedef struct packed {
		logic target_zero;
		logic fill_done;
		logic out_free;
	} mcc_sts_t;

endpackage

@@ rtl/mcc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mcc_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/mcc_ctrl.sv @@
// Control state machine of the min coin change table.
// Depends on mcc_pkg; drives mcc_dp through the command struct.
module mcc_ctrl
	import mcc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  logic     s_tuser,
	input  mcc_sts_t sts,
	output mcc_cmd_t cmd
);

	mcc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = (s_tuser == MODE_QUERY) ? ST_RD : ST_ZERO;
				end
			end
			ST_ZERO: begin
				cmd.zero_wr = 1'b1;
				state_d     = sts.target_zero ? ST_RD : ST_FILL;
			end
			ST_FILL: begin
				cmd.fill = 1'b1;
				if (sts.fill_done) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/mcc_dp.sv @@
// Datapath of the min coin change table: amount/slot counters, best-coin fold,
// table RAM and output register. Depends on mcc_pkg, mcc_ram, assert_macros.svh.
`include "assert_macros.svh"

module mcc_dp
	import mcc_pkg::*;
#(
	parameter int MAX_AMOUNT = DEF_MAX_AMOUNT,
	parameter int COIN_SLOTS = DEF_COIN_SLOTS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [AMT_W-1:0]                      amount_in,
	input  logic                                  mode_in,
	input  mcc_cmd_t                              cmd,
	output mcc_sts_t                              sts,
	input  logic [SLOT_W-1:0]                     coin_count,
	input  logic [NUM_COIN_REGS-1:0][COIN_W-1:0]  coin_value,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [M_TDATA_W-1:0]                  m_tdata,
	output logic                                  m_tuser
);

	localparam int MaxEff = (MAX_AMOUNT < AMT_MAX) ? MAX_AMOUNT : AMT_MAX;
	localparam int Depth  = MaxEff + 1;
	localparam int AW     = $clog2(Depth);
	localparam int NSel   = 1 << SLOT_W;
	localparam int PadW   = M_TDATA_W - AMT_W - CNT_W - SLOT_W;
	localparam logic [AMT_W-1:0]  MaxAmt = AMT_W'(MaxEff);
	localparam logic [SLOT_W-1:0] Slots  = SLOT_W'(COIN_SLOTS);

	logic [AMT_W-1:0]  amt_q, a_q, limit_q;
	logic [SLOT_W-1:0] phase_q, slot_s1, best_slot_q;
	logic [CNT_W-1:0]  best_q;
	logic              valid_s1, found_q, done_q;

	logic [AMT_W-1:0]  amt_out_q;
	logic [CNT_W-1:0]  fewest_q;
	logic [SLOT_W-1:0] slot_q;
	logic              reach_q, m_tvalid_q;

	logic [SLOT_W-1:0]             used;
	logic [NSel-1:0][COIN_W-1:0]   coin_ext;
	logic [COIN_W-1:0]             coin_sel;
	logic [AMT_W-1:0]              amt_sat, pred;
	logic                          rd_ok, last_phase;
	logic [CNT_W-1:0]              cand, nbest;
	logic [SLOT_W-1:0]             nslot;
	logic                          take, nfound, hit;
	mcc_entry_t                    rdata, wdata;
	logic                          ram_we, ram_re;
	logic [AW-1:0]                 ram_waddr, ram_raddr;

	assign used = (coin_count > Slots) ? Slots : coin_count;

	always_comb begin
		coin_ext = '0;
		for (int i = 0; i < NUM_COIN_REGS; i++) begin
			coin_ext[i] = coin_value[i];
		end
	end

	assign coin_sel   = coin_ext[phase_q];
	assign last_phase = (phase_q == used);
	assign rd_ok      = (phase_q < used) && (coin_sel != '0) && (coin_sel <= a_q);
	assign pred       = a_q - coin_sel;

	assign amt_sat = (mode_in == MODE_COMPUTE && amount_in > MaxAmt) ? MaxAmt : amount_in;

	// fold the candidate read in the previous phase into the running best
	assign cand   = (rdata.count == COUNT_SAT) ? COUNT_SAT : rdata.count + CNT_W'(1);
	assign take   = valid_s1 && rdata.reach && (!found_q || cand < best_q);
	assign nfound = found_q || take;
	assign nbest  = take ? cand : best_q;
	assign nslot  = take ? slot_s1 : best_slot_q;

	always_comb begin
		wdata = '0;
		if (cmd.zero_wr) begin
			wdata.reach = 1'b1;
		end else if (nfound) begin
			wdata.reach = 1'b1;
			wdata.count = nbest;
			wdata.slot  = nslot;
		end
	end

	assign ram_we    = cmd.zero_wr || (cmd.fill && last_phase);
	assign ram_waddr = cmd.zero_wr ? '0 : a_q[AW-1:0];
	assign ram_re    = (cmd.fill && rd_ok) || cmd.rd;
	assign ram_raddr = cmd.rd ? amt_q[AW-1:0] : pred[AW-1:0];

	mcc_ram #(
		.WIDTH($bits(mcc_entry_t)),
		.DEPTH(Depth)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amt_q    <= '0;
			a_q      <= '0;
			phase_q  <= '0;
			valid_s1 <= 1'b0;
			found_q  <= 1'b0;
			limit_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			if (cmd.accept) begin
				amt_q <= amt_sat;
			end
			if (cmd.zero_wr) begin
				a_q      <= AMT_W'(1);
				phase_q  <= '0;
				valid_s1 <= 1'b0;
				found_q  <= 1'b0;
				limit_q  <= amt_q;
				done_q   <= 1'b1;
			end else if (cmd.fill) begin
				if (last_phase) begin
					a_q      <= a_q + AMT_W'(1);
					phase_q  <= '0;
					valid_s1 <= 1'b0;
					found_q  <= 1'b0;
				end else begin
					phase_q  <= phase_q + SLOT_W'(1);
					valid_s1 <= rd_ok;
					found_q  <= nfound;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fill && !last_phase) begin
			slot_s1     <= phase_q;
			best_q      <= nbest;
			best_slot_q <= nslot;
		end
	end

	assign hit = done_q && (amt_q <= limit_q) && rdata.reach;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			amt_out_q <= amt_q;
			reach_q   <= hit;
			fewest_q  <= hit ? rdata.count : '0;
			slot_q    <= hit ? rdata.slot : '0;
		end
	end

	// target_zero is looked at in ST_ZERO, fill_done in ST_FILL, out_free in ST_OUT
	assign sts.target_zero = (amt_q == '0);
	assign sts.fill_done   = last_phase && (a_q == amt_q);
	assign sts.out_free    = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = reach_q;
	assign m_tdata  = {{PadW{1'b0}}, slot_q, fewest_q, amt_out_q};

	`ASSERT_IMP(a_no_rw_clash, clk, arst_n, ram_we, !ram_re)
	`ASSERT_IMP(a_phase_bound, clk, arst_n, cmd.fill, phase_q <= used)
	`ASSERT_IMP(a_unreach_clear, clk, arst_n, m_tvalid_q && !reach_q, fewest_q == '0 && slot_q == '0)
	`ASSERT_IMP(a_reach_counted, clk, arst_n, m_tvalid_q && reach_q && amt_out_q != '0, fewest_q != '0)

endmodule

@@ rtl/min_coin_change_table.sv @@
// Min coin change table: input beat holds a mode and an amount.
// Mode compute fills the table from 0 up to the amount and returns its entry;
// mode query reads back one stored entry. Every input beat yields one output beat.
// Config port: cfg_index 0 is coin_count, 1..7 are coin values of slots 0..6;
// always ready; written only while the block is idle: the user must keep to this, the block does not enforce it.
// Flow: a query goes from accept through one table read to the output register. A compute
// writes entry 0 and then walks the amounts 1 to target over the used_slots, where used_slots
// is coin_count limited to COIN_SLOTS: at most one table read per coin slot plus one write
// per amount, all through the single read and single write port of the table RAM.
// The next beat can be accepted in the cycle after the output register loads.
// One item is worked at a time; s_tready is high only between items.
// The output register holds a finished beat while m_tready is low; the next
// input beat is still accepted and worked, and waits for the register to free.
// Reset: coin_count 1, all coin values 1, no table computed (queries report
// unreachable). The table RAM itself is not cleared.
module min_coin_change_table
	import mcc_pkg::*;
#(
	parameter int MAX_AMOUNT = DEF_MAX_AMOUNT,
	parameter int COIN_SLOTS = DEF_COIN_SLOTS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // [9:0] amount
	input  logic                  s_tuser,   // [0] mode
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // [9:0] amount_out, [19:10] fewest_coins,
	                                         // [22:20] last_coin_slot
	output logic                  m_tuser,   // [0] reachable
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [SLOT_W-1:0]                    coin_count_q;
	logic [NUM_COIN_REGS-1:0][COIN_W-1:0] coin_value_q;
	mcc_cmd_t                             cmd;
	mcc_sts_t                             sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coin_count_q <= SLOT_W'(1);
			for (int i = 0; i < NUM_COIN_REGS; i++) begin
				coin_value_q[i] <= COIN_W'(1);
			end
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_COIN_COUNT) begin
				coin_count_q <= cfg_data[SLOT_W-1:0];
			end
			for (int i = 0; i < NUM_COIN_REGS; i++) begin
				if (cfg_index == REG_COIN_VALUE_0 + CFG_IDX_W'(i)) begin
					coin_value_q[i] <= cfg_data[COIN_W-1:0];
				end
			end
		end
	end

	mcc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser (s_tuser),
		.sts     (sts),
		.cmd     (cmd)
	);

	mcc_dp #(
		.MAX_AMOUNT(MAX_AMOUNT),
		.COIN_SLOTS(COIN_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.amount_in (s_tdata[AMT_W-1:0]),
		.mode_in   (s_tuser),
		.cmd       (cmd),
		.sts       (sts),
		.coin_count(coin_count_q),
		.coin_value(coin_value_q),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
